>>> src/indexed_min_heap_unit_assert.svh
// Assertion macros shared by the indexed min-heap RTL.
`ifndef INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define IMH_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define IMH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define IMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/imh_pkg.sv
// Types and constants of the indexed min-heap unit.
package imh_pkg;

    // Fixed field widths of the command and result beats.
    localparam int NODE_BITS    = 8;
    localparam int IN_KEY_BITS  = 32;
    localparam int ENTRY_BITS   = 9;

    // Command codes.
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status STAT_DONE    = 2'd0;
    localparam t_status STAT_FULL    = 2'd1;
    localparam t_status STAT_EMPTY   = 2'd2;
    localparam t_status STAT_IGNORED = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXT,
        ST_DEC_RD,
        ST_DEC_CMP,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_OUT
    } t_state;

endpackage

>>> src/indexed_min_heap_unit.sv
// Indexed binary min-heap with insert, decrease-key and extract-min, one command per beat.
// Commands are taken one at a time, in the idle state after the previous result is loaded.
// The result sits in an output register, so the next command is taken while it waits.
// Reset clears the node valid bits, the entry count and the output valid; no clearing pass.
`include "indexed_min_heap_unit_assert.svh"

module indexed_min_heap_unit
    import imh_pkg::*;
#(
    parameter int NODES    = 256,
    parameter int KEY_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_cmd,
    input  logic [NODE_BITS-1:0]   i_node_id,
    input  logic [IN_KEY_BITS-1:0] i_key,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [NODE_BITS-1:0]   o_out_node,
    output logic [IN_KEY_BITS-1:0] o_out_key,
    output logic [1:0]             o_status,
    output logic [ENTRY_BITS-1:0]  o_entries
);

    localparam int AW        = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW        = $clog2(NODES + 1);
    localparam int DW        = AW + 2;
    localparam int MAP_DEPTH = (NODES < 256) ? NODES : 256;
    localparam int MW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(NODES);

    // Heap storage and the node-to-position map.
    logic [KEY_BITS-1:0]  r_key_mem  [NODES];
    logic [NODE_BITS-1:0] r_node_mem [NODES];
    logic [AW-1:0]        r_pos_mem  [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_node_valid;

    // Sequencer and datapath registers.
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_p, n_p;
    logic [NODE_BITS-1:0] r_cur_node, n_cur_node;
    logic [KEY_BITS-1:0]  r_cur_key, n_cur_key;
    logic [NODE_BITS-1:0] r_res_node, n_res_node;
    logic [IN_KEY_BITS-1:0] r_res_key, n_res_key;
    t_status              r_res_status, n_res_status;

    // Registered memory read data.
    logic [KEY_BITS-1:0]  r_rd0_key, r_rd1_key;
    logic [NODE_BITS-1:0] r_rd0_node, r_rd1_node;
    logic [AW-1:0]        r_map_pos;

    // Output register.
    logic                   r_out_valid;
    logic [NODE_BITS-1:0]   r_out_node;
    logic [IN_KEY_BITS-1:0] r_out_key;
    t_status                r_out_status;
    logic [ENTRY_BITS-1:0]  r_out_entries;

    // Combinational control.
    logic                 accept;
    logic                 in_node_ok;
    logic                 in_present;
    logic                 heap_full;
    logic                 out_free;
    logic                 load_out;
    logic [AW-1:0]        up_pos;
    logic [DW-1:0]        left_ext, right_ext;
    logic [AW-1:0]        left_pos, right_pos;
    logic                 left_done, right_ok, pick_right;
    logic [KEY_BITS-1:0]  best_key;
    logic [NODE_BITS-1:0] best_node;
    logic [AW-1:0]        best_pos;
    logic [KEY_BITS-1:0]  cmp_a, cmp_b;
    logic                 cmp_lt;
    logic [AW-1:0]        rd0_addr, rd1_addr;
    logic                 heap_we;
    logic [AW-1:0]        heap_waddr;
    logic [KEY_BITS-1:0]  heap_wkey;
    logic [NODE_BITS-1:0] heap_wnode;
    logic                 map_we;
    logic [MW-1:0]        map_waddr;
    logic [AW-1:0]        map_wpos;
    logic [MW-1:0]        map_raddr;
    logic                 valid_clr;

    // Handshake and command decode.
    assign o_stall    = (r_state != ST_IDLE);
    assign accept     = i_valid && !o_stall;
    assign in_node_ok = ({1'b0, i_node_id} < 9'(MAP_DEPTH));
    assign in_present = r_node_valid[i_node_id[MW-1:0]];
    assign heap_full  = (r_count == FULL_COUNT);
    assign out_free   = !r_out_valid || !i_stall;

    // The map is read for the incoming node while idle, then for the node being worked on.
    assign map_raddr  = (r_state == ST_IDLE) ? i_node_id[MW-1:0] : r_cur_node[MW-1:0];

    // Tree navigation around the hole position.
    assign up_pos     = AW'((r_p - AW'(1)) >> 1);
    assign left_ext   = {1'b0, r_p, 1'b1};
    assign right_ext  = left_ext + DW'(1);
    assign left_pos   = left_ext[AW-1:0];
    assign right_pos  = right_ext[AW-1:0];
    assign left_done  = (left_ext >= DW'(r_count));
    assign right_ok   = (right_ext < DW'(r_count));

    // Child select: the right child wins only when strictly smaller.
    assign pick_right = right_ok && (r_rd1_key < r_rd0_key);
    assign best_key   = pick_right ? r_rd1_key  : r_rd0_key;
    assign best_node  = pick_right ? r_rd1_node : r_rd0_node;
    assign best_pos   = pick_right ? right_pos  : left_pos;

    // Shared key comparator for the sift decisions.
    always_comb begin
        cmp_a = r_cur_key;
        cmp_b = r_rd0_key;
        if (r_state == ST_DN_CMP) begin
            cmp_a = best_key;
            cmp_b = r_cur_key;
        end
    end
    assign cmp_lt = (cmp_a < cmp_b);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_EXTRACT) begin
                        n_state = (r_count == '0) ? ST_OUT : ST_EXT;
                    end else if (!in_node_ok) begin
                        n_state = ST_OUT;
                    end else if (in_present) begin
                        n_state = ST_DEC_RD;
                    end else if (heap_full) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_UP_RD;
                    end
                end
            end
            ST_EXT:     n_state = (r_count == CW'(1)) ? ST_OUT : ST_DN_RD;
            ST_DEC_RD:  n_state = ST_DEC_CMP;
            ST_DEC_CMP: n_state = cmp_lt ? ST_UP_RD : ST_OUT;
            ST_UP_RD:   n_state = (r_p == '0) ? ST_OUT : ST_UP_CMP;
            ST_UP_CMP:  n_state = cmp_lt ? ST_UP_RD : ST_OUT;
            ST_DN_RD:   n_state = left_done ? ST_OUT : ST_DN_CMP;
            ST_DN_CMP:  n_state = cmp_lt ? ST_DN_RD : ST_OUT;
            ST_OUT:     n_state = out_free ? ST_IDLE : ST_OUT;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory ports and datapath updates.
    always_comb begin
        n_count      = r_count;
        n_p          = r_p;
        n_cur_node   = r_cur_node;
        n_cur_key    = r_cur_key;
        n_res_node   = r_res_node;
        n_res_key    = r_res_key;
        n_res_status = r_res_status;
        rd0_addr     = r_p;
        rd1_addr     = r_p;
        heap_we      = 1'b0;
        heap_waddr   = r_p;
        heap_wkey    = r_cur_key;
        heap_wnode   = r_cur_node;
        map_we       = 1'b0;
        map_waddr    = r_cur_node[MW-1:0];
        map_wpos     = r_p;
        valid_clr    = 1'b0;
        load_out     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // Root and last entry for an extract; the map read runs alongside.
                rd0_addr = '0;
                rd1_addr = AW'(r_count - CW'(1));
                if (accept) begin
                    n_res_node   = '0;
                    n_res_key    = '0;
                    n_res_status = STAT_DONE;
                    n_cur_node   = i_node_id;
                    n_cur_key    = KEY_BITS'(i_key);
                    if (i_cmd == CMD_EXTRACT) begin
                        if (r_count == '0) begin
                            n_res_status = STAT_EMPTY;
                        end
                    end else if (!in_node_ok) begin
                        n_res_status = STAT_IGNORED;
                    end else if (!in_present) begin
                        if (heap_full) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            n_p     = AW'(r_count);
                            n_count = r_count + CW'(1);
                        end
                    end
                end
            end
            ST_EXT: begin
                // Report the root, drop it from the map and lift the last entry.
                n_res_node = r_rd0_node;
                n_res_key  = IN_KEY_BITS'(r_rd0_key);
                valid_clr  = 1'b1;
                map_waddr  = r_rd0_node[MW-1:0];
                n_count    = r_count - CW'(1);
                n_cur_node = r_rd1_node;
                n_cur_key  = r_rd1_key;
                n_p        = '0;
            end
            ST_DEC_RD: begin
                rd0_addr = r_map_pos;
            end
            ST_DEC_CMP: begin
                if (cmp_lt) begin
                    n_p = r_map_pos;
                end else begin
                    n_res_status = STAT_IGNORED;
                end
            end
            ST_UP_RD: begin
                if (r_p == '0) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                end else begin
                    rd0_addr = up_pos;
                end
            end
            ST_UP_CMP: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
                if (cmp_lt) begin
                    // Parent moves down into the hole.
                    heap_wkey  = r_rd0_key;
                    heap_wnode = r_rd0_node;
                    map_waddr  = r_rd0_node[MW-1:0];
                    n_p        = up_pos;
                end
            end
            ST_DN_RD: begin
                if (left_done) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                end else begin
                    rd0_addr = left_pos;
                    rd1_addr = right_pos;
                end
            end
            ST_DN_CMP: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
                if (cmp_lt) begin
                    // Smaller child moves up into the hole.
                    heap_wkey  = best_key;
                    heap_wnode = best_node;
                    map_waddr  = best_node[MW-1:0];
                    n_p        = best_pos;
                end
            end
            ST_OUT: begin
                load_out = out_free;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // Heap memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            r_key_mem[heap_waddr]  <= heap_wkey;
            r_node_mem[heap_waddr] <= heap_wnode;
        end
        r_rd0_key  <= r_key_mem[rd0_addr];
        r_rd0_node <= r_node_mem[rd0_addr];
        r_rd1_key  <= r_key_mem[rd1_addr];
        r_rd1_node <= r_node_mem[rd1_addr];
    end

    // Position map memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_pos_mem[map_waddr] <= map_wpos;
        end
        r_map_pos <= r_pos_mem[map_raddr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_node_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (valid_clr) begin
                r_node_valid[map_waddr] <= 1'b0;
            end else if (map_we) begin
                r_node_valid[map_waddr] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath and output payload.
    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_cur_node   <= n_cur_node;
        r_cur_key    <= n_cur_key;
        r_res_node   <= n_res_node;
        r_res_key    <= n_res_key;
        r_res_status <= n_res_status;
        if (load_out) begin
            r_out_node    <= r_res_node;
            r_out_key     <= r_res_key;
            r_out_status  <= r_res_status;
            r_out_entries <= ENTRY_BITS'(r_count);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_node = r_out_node;
    assign o_out_key  = r_out_key;
    assign o_status   = r_out_status;
    assign o_entries  = r_out_entries;

    // Checks on the sequencer and the entry count.
    `IMH_ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT, "entry count above capacity")
    `IMH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != ST_IDLE, "accepted beat left no work")
    `IMH_ASSERT_NEXT(a_extract_count, i_clk, i_rst_n, r_state == ST_EXT, r_count == $past(r_count) - CW'(1), "extract did not drop one entry")
    `IMH_ASSERT_IMPLIES(a_empty_zero, i_clk, i_rst_n, r_state == ST_OUT && r_res_status == STAT_EMPTY, r_res_node == '0 && r_res_key == '0, "empty extract reports a node")

endmodule

>>> dv/indexed_min_heap_unit_tb.sv
// Self-checking testbench for the indexed min-heap unit with an in-bench heap predictor.
`timescale 1ns / 100ps

module indexed_min_heap_unit_tb;
    import imh_pkg::*;

    localparam int HEAP_DEPTH      = 256;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 40;
    localparam int MAX_PRINTED     = 50;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [NODE_BITS-1:0]   node;
        logic [IN_KEY_BITS-1:0] key;
        t_status                status;
        logic [ENTRY_BITS-1:0]  entries;
    } t_heap_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic                   i_cmd = CMD_INSERT;
    logic [NODE_BITS-1:0]   i_node_id = '0;
    logic [IN_KEY_BITS-1:0] i_key = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [NODE_BITS-1:0]   o_out_node;
    logic [IN_KEY_BITS-1:0] o_out_key;
    logic [1:0]             o_status;
    logic [ENTRY_BITS-1:0]  o_entries;

    indexed_min_heap_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_node_id  (i_node_id),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_node (o_out_node),
        .o_out_key  (o_out_key),
        .o_status   (o_status),
        .o_entries  (o_entries)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted heap contents and the results still owed by the block.
    logic [IN_KEY_BITS-1:0] shadow_key   [HEAP_DEPTH];
    logic [NODE_BITS-1:0]   shadow_node  [HEAP_DEPTH];
    int unsigned            slot_of_node [HEAP_DEPTH];
    bit                     node_queued  [HEAP_DEPTH];
    int unsigned            shadow_count = 0;
    t_heap_result           pending_results[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int long_hold_asked    = 0;
    int mismatch_count     = 0;
    int result_index       = 0;

    // Writes one heap slot and keeps the node's position in step.
    function automatic void place_entry(int unsigned p, logic [NODE_BITS-1:0] n,
                                        logic [IN_KEY_BITS-1:0] k);
        shadow_key[p]   = k;
        shadow_node[p]  = n;
        slot_of_node[n] = p;
        node_queued[n]  = 1'b1;
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic [IN_KEY_BITS-1:0] ka;
        logic [NODE_BITS-1:0]   na;
        ka = shadow_key[a];
        na = shadow_node[a];
        place_entry(a, shadow_node[b], shadow_key[b]);
        place_entry(b, na, ka);
    endfunction

    // Moves an entry toward the root while it is strictly below its parent.
    function automatic void sift_toward_root(int unsigned p);
        int unsigned parent;
        while (p > 0) begin
            parent = (p - 1) / 2;
            if (!(shadow_key[p] < shadow_key[parent])) break;
            swap_entries(p, parent);
            p = parent;
        end
    endfunction

    // Moves an entry down past the smaller child; ties go to the left child.
    function automatic void sift_toward_leaves(int unsigned p);
        int unsigned lc;
        int unsigned pick;
        forever begin
            lc = 2 * p + 1;
            if (lc >= shadow_count) break;
            pick = lc;
            if (lc + 1 < shadow_count && shadow_key[lc + 1] < shadow_key[lc]) pick = lc + 1;
            if (!(shadow_key[pick] < shadow_key[p])) break;
            swap_entries(p, pick);
            p = pick;
        end
    endfunction

    // Applies one command to the shadow heap and returns the result it must produce.
    function automatic t_heap_result apply_heap_command(logic cmd, logic [NODE_BITS-1:0] n,
                                                        logic [IN_KEY_BITS-1:0] k);
        t_heap_result r;
        int unsigned  last;
        r = '0;
        r.status = STAT_DONE;
        if (cmd == CMD_EXTRACT) begin
            if (shadow_count == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                last = shadow_count - 1;
                r.node = shadow_node[0];
                r.key  = shadow_key[0];
                node_queued[shadow_node[0]] = 1'b0;
                shadow_count = last;
                if (last > 0) begin
                    place_entry(0, shadow_node[last], shadow_key[last]);
                    sift_toward_leaves(0);
                end
            end
        end else if (node_queued[n]) begin
            if (k < shadow_key[slot_of_node[n]]) begin
                shadow_key[slot_of_node[n]] = k;
                sift_toward_root(slot_of_node[n]);
            end else begin
                r.status = STAT_IGNORED;
            end
        end else if (shadow_count >= HEAP_DEPTH) begin
            r.status = STAT_FULL;
        end else begin
            shadow_count = shadow_count + 1;
            place_entry(shadow_count - 1, n, k);
            sift_toward_root(shadow_count - 1);
        end
        r.entries = ENTRY_BITS'(shadow_count);
        return r;
    endfunction

    // Keys drawn wide, on whole units, tiny, or at the extremes so ties happen often.
    function automatic logic [IN_KEY_BITS-1:0] draw_key();
        case ($urandom_range(3))
            0: return $urandom;
            1: return IN_KEY_BITS'($urandom_range(15)) << 16;
            2: return IN_KEY_BITS'($urandom_range(7));
            default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < MAX_PRINTED)
            $display("result %0d: %s got %0h want %0h", result_index, what, got, want);
        mismatch_count++;
    endtask

    // Offers one command beat, holds it until accepted, then records its expected result.
    task automatic send_command(input logic cmd, input logic [NODE_BITS-1:0] n,
                                input logic [IN_KEY_BITS-1:0] k);
        t_heap_result want;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_node_id <= n;
        i_key     <= k;
        do @(posedge i_clk); while (o_stall);
        want = apply_heap_command(cmd, n, k);
        pending_results = {pending_results, want};
    endtask

    // Stops offering and waits for every owed result.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    always @(posedge i_clk) begin : receiver_side
        int hold_left;
        int hold_served;
        if (hold_left == 0 && hold_served != long_hold_asked) begin
            hold_served = hold_served + 1;
            hold_left   = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Result checker and watchdog on cycles with no beat moving.
    always @(posedge i_clk) begin : result_checker
        int quiet_cycles;
        t_heap_result want;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat, entries", o_entries, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_node !== want.node) report_mismatch("out_node", o_out_node, want.node);
                    if (o_out_key !== want.key) report_mismatch("out_key", o_out_key, want.key);
                    if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                    if (o_entries !== want.entries) report_mismatch("entries", o_entries, want.entries);
                end
                result_index++;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Corners: empty extract, extreme keys and nodes, decrease, not-smaller, ties.
    task automatic test_directed_corners();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_command(CMD_EXTRACT, 8'h00, 32'h0000_0000);
        send_command(CMD_INSERT,  8'h00, 32'h0000_0000);
        send_command(CMD_INSERT,  8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_INSERT,  8'hAA, 32'h5555_5555);
        send_command(CMD_INSERT,  8'h55, 32'hAAAA_AAAA);
        // Lowered key climbs past its parent.
        send_command(CMD_INSERT,  8'hFF, 32'h8000_0000);
        send_command(CMD_INSERT,  8'hFF, 32'h8000_0000);
        send_command(CMD_INSERT,  8'hFF, 32'hFFFF_FFFF);
        // Equal keys must not swap.
        send_command(CMD_INSERT,  8'h01, 32'h0001_0000);
        send_command(CMD_INSERT,  8'h02, 32'h0001_0000);
        send_command(CMD_INSERT,  8'h03, 32'h0001_0000);
        send_command(CMD_INSERT,  8'h02, 32'h0000_0000);
        send_command(CMD_INSERT,  8'h03, 32'h0000_FFFF);
        repeat (9) send_command(CMD_EXTRACT, 8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_INSERT,  8'h7F, 32'h0000_0001);
        send_command(CMD_EXTRACT, 8'h00, 32'h0000_0000);
        wait_for_drain();
    endtask

    // Every node in, decrease and not-smaller at full depth, then drain to empty.
    task automatic test_fill_and_drain();
        logic [NODE_BITS-1:0] order[HEAP_DEPTH];
        logic [NODE_BITS-1:0] t;
        int j;
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
        for (int i = 0; i < HEAP_DEPTH; i++) order[i] = NODE_BITS'(i);
        for (int i = HEAP_DEPTH - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < HEAP_DEPTH; i++)
            send_command(CMD_INSERT, order[i], draw_key() | 32'h0000_0001);
        send_command(CMD_INSERT, order[0], 32'hFFFF_FFFF);
        send_command(CMD_INSERT, order[HEAP_DEPTH - 1], 32'h0000_0000);
        repeat (HEAP_DEPTH + 1) send_command(CMD_EXTRACT, NODE_BITS'($urandom), $urandom);
        wait_for_drain();
    endtask

    // The receiver holds off while commands keep coming, so the block backs up.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        long_hold_asked++;
        repeat (30) send_command($urandom_range(99) < 30 ? CMD_EXTRACT : CMD_INSERT,
                                 NODE_BITS'($urandom), draw_key());
        wait_for_drain();
        repeat (10) send_command(CMD_EXTRACT, NODE_BITS'($urandom), $urandom);
        wait_for_drain();
    endtask

    // Random mixes under each idling pattern; a narrow node range favors decreases.
    task automatic test_random_mix();
        int idle_of[4]  = '{0, 63, 0, 11};
        int stall_of[4] = '{0, 0, 63, 11};
        int node_hi;
        int extract_pct;
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = idle_of[ph];
            receiver_stall_pct = stall_of[ph];
            node_hi     = (ph % 2 == 0) ? 31 : 255;
            extract_pct = (ph % 2 == 0) ? 45 : 30;
            repeat (250) begin
                if ($urandom_range(99) < extract_pct)
                    send_command(CMD_EXTRACT, NODE_BITS'($urandom), $urandom);
                else
                    send_command(CMD_INSERT, NODE_BITS'($urandom_range(node_hi)), draw_key());
            end
            wait_for_drain();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_fill_and_drain();
        test_backpressure();
        test_random_mix();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
